@@ design/cfbs_pkg.sv @@
// Shared constants for the clipped fill / blit span engine.
// Field widths, command codes and register indexes; no dependencies.
`timescale 1ns / 1ps

package cfbs_pkg;

    localparam int DIM_W       = 13;   // window dimension / span length width
    localparam int MAX_DIM_DEF = 4096;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 32;
    localparam int PITCH_W     = 16;
    localparam int DEST_W      = 24;
    localparam int SRC_W       = 32;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [KIND_W-1:0] KIND_FILL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COPY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 1'b1;

endpackage

@@ design/clipped_fill_blit_span_engine_top.sv @@
// Timing: a command word loads the row walk in the cycle after acceptance; a step word
// goes from the input stage to the output register when that is free. Throughput: one
// word per cycle unless the output stalls; clipping sits in the input stage, the row
// address multiplies in the walk stage, and the output register decouples the two sides.
// Reset (synchronous, active low) clears the window size, the walk and both valid flags.
// Depends on cfbs_pkg.
`timescale 1ns / 1ps

module clipped_fill_blit_span_engine_top #(
    parameter int MAX_DIM = cfbs_pkg::MAX_DIM_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [cfbs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cfbs_pkg::DIM_W-1:0]            i_cfg_data,
    // command / step words
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [cfbs_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [cfbs_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [cfbs_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [cfbs_pkg::COORD_W-1:0]   i_rect_width,
    input  logic signed [cfbs_pkg::COORD_W-1:0]   i_rect_height,
    input  logic [cfbs_pkg::COLOR_W-1:0]          i_fill_color,
    input  logic [cfbs_pkg::PITCH_W-1:0]          i_src_pitch,
    // span words
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [cfbs_pkg::DEST_W-1:0]           o_dest_index,
    output logic [cfbs_pkg::SRC_W-1:0]            o_src_index,
    output logic [cfbs_pkg::DIM_W-1:0]            o_span_length,
    output logic [cfbs_pkg::COLOR_W-1:0]          o_span_color,
    output logic                                  o_is_copy,
    output logic                                  o_last_span
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = cfbs_pkg::COORD_W + 2;   // room for coordinate sums

    // configuration registers
    logic [cfbs_pkg::DIM_W-1:0] r_win_width, r_win_height;

    // clamp window to MAX_DIM
    logic [DW-1:0] w_bw, w_bh;
    assign w_bw = (r_win_width  > cfbs_pkg::DIM_W'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(r_win_width);
    assign w_bh = (r_win_height > cfbs_pkg::DIM_W'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(r_win_height);

    // ---------------- clip logic at the input ----------------
    logic signed [CW-1:0] w_bw_s, w_bh_s;
    logic signed [CW-1:0] w_x0, w_y0, w_x1, w_y1;
    logic signed [CW-1:0] w_x0c, w_y0c, w_x1c, w_y1c;
    logic signed [CW-1:0] w_xdiff, w_ydiff, w_xneg, w_yneg;
    logic                 w_nonempty;

    assign w_bw_s = $signed({{(CW-DW){1'b0}}, w_bw});
    assign w_bh_s = $signed({{(CW-DW){1'b0}}, w_bh});
    assign w_x0   = CW'(i_pos_x);
    assign w_y0   = CW'(i_pos_y);
    assign w_x1   = w_x0 + CW'(i_rect_width);
    assign w_y1   = w_y0 + CW'(i_rect_height);
    assign w_x0c  = (w_x0 < 0) ? '0 : w_x0;
    assign w_y0c  = (w_y0 < 0) ? '0 : w_y0;
    assign w_x1c  = (w_x1 > w_bw_s) ? w_bw_s : w_x1;
    assign w_y1c  = (w_y1 > w_bh_s) ? w_bh_s : w_y1;
    assign w_xdiff = w_x1c - w_x0c;
    assign w_ydiff = w_y1c - w_y0c;
    assign w_xneg  = -w_x0;
    assign w_yneg  = -w_y0;
    assign w_nonempty = (w_x0c < w_x1c) && (w_y0c < w_y1c);

    // ---------------- input stage ----------------
    logic                           r_a_valid;
    logic [cfbs_pkg::KIND_W-1:0]    r_a_kind;
    logic                           r_a_load;
    logic [DW-1:0]                  r_a_x0, r_a_y0, r_a_run, r_a_rows;
    logic [cfbs_pkg::COORD_W-1:0]   r_a_sx, r_a_sy;
    logic [cfbs_pkg::COLOR_W-1:0]   r_a_color;
    logic [cfbs_pkg::PITCH_W-1:0]   r_a_pitch;

    // ---------------- walk state ----------------
    logic                           r_walk_active, r_copy_mode;
    logic [DW-1:0]                  r_rows_left, r_run_length;
    logic [cfbs_pkg::DEST_W-1:0]    r_cur_dest;
    logic [cfbs_pkg::SRC_W-1:0]     r_cur_src;
    logic [cfbs_pkg::COLOR_W-1:0]   r_held_color;
    logic [cfbs_pkg::PITCH_W-1:0]   r_held_pitch;

    logic w_is_cmd, w_emit, w_out_free, w_adv;

    assign w_is_cmd   = (r_a_kind == cfbs_pkg::KIND_FILL) || (r_a_kind == cfbs_pkg::KIND_COPY);
    assign w_emit     = r_a_valid && (r_a_kind == cfbs_pkg::KIND_STEP) && r_walk_active;
    assign w_out_free = !o_valid || i_ready;
    assign w_adv      = r_a_valid && (!w_emit || w_out_free);
    assign o_ready    = !r_a_valid || w_adv;

    // start addresses of the clipped rectangle
    logic [2*DW-1:0]              w_row_base;
    logic [cfbs_pkg::SRC_W-1:0]   w_src_base;
    logic [cfbs_pkg::DEST_W-1:0]  w_dest_start;
    logic [cfbs_pkg::SRC_W-1:0]   w_src_start;

    assign w_row_base   = (2*DW)'(r_a_y0) * (2*DW)'(w_bw);
    assign w_src_base   = cfbs_pkg::SRC_W'(r_a_sy) * cfbs_pkg::SRC_W'(r_a_pitch);
    assign w_dest_start = cfbs_pkg::DEST_W'(w_row_base) + cfbs_pkg::DEST_W'(r_a_x0);
    assign w_src_start  = w_src_base + cfbs_pkg::SRC_W'(r_a_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_width  <= '0;
            r_win_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfbs_pkg::CFG_WIN_WIDTH:  r_win_width  <= i_cfg_data;
                cfbs_pkg::CFG_WIN_HEIGHT: r_win_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_a_kind  <= i_kind;
            r_a_load  <= w_nonempty;
            r_a_x0    <= DW'(w_x0c);
            r_a_y0    <= DW'(w_y0c);
            r_a_run   <= DW'(w_xdiff);
            r_a_rows  <= DW'(w_ydiff);
            r_a_sx    <= (w_x0 < 0) ? cfbs_pkg::COORD_W'(w_xneg) : '0;
            r_a_sy    <= (w_y0 < 0) ? cfbs_pkg::COORD_W'(w_yneg) : '0;
            r_a_color <= i_fill_color;
            r_a_pitch <= i_src_pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_active <= 1'b0;
            r_copy_mode   <= 1'b0;
            r_rows_left   <= '0;
        end else if (w_adv) begin
            if (w_is_cmd) begin
                // a new command drops any running walk
                r_walk_active <= r_a_load;
                if (r_a_load) begin
                    r_copy_mode <= (r_a_kind == cfbs_pkg::KIND_COPY);
                    r_rows_left <= r_a_rows;
                end
            end else if (w_emit) begin
                if (r_rows_left <= DW'(1)) begin
                    r_rows_left   <= '0;
                    r_walk_active <= 1'b0;
                end else begin
                    r_rows_left <= r_rows_left - DW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_is_cmd && r_a_load) begin
                r_run_length <= r_a_run;
                r_cur_dest   <= w_dest_start;
                if (r_a_kind == cfbs_pkg::KIND_COPY) begin
                    r_held_pitch <= r_a_pitch;
                    r_held_color <= '0;
                    r_cur_src    <= w_src_start;
                end else begin
                    r_held_pitch <= '0;
                    r_held_color <= r_a_color;
                    r_cur_src    <= '0;
                end
            end else if (w_emit && r_rows_left > DW'(1)) begin
                // advance one row
                r_cur_dest <= r_cur_dest + cfbs_pkg::DEST_W'(w_bw);
                if (r_copy_mode) begin
                    r_cur_src <= r_cur_src + cfbs_pkg::SRC_W'(r_held_pitch);
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_free) begin
            o_valid <= w_emit;
        end
        if (w_out_free && w_emit) begin
            o_dest_index  <= r_cur_dest;
            o_src_index   <= r_copy_mode ? r_cur_src : '0;
            o_span_length <= cfbs_pkg::DIM_W'(r_run_length);
            o_span_color  <= r_copy_mode ? '0 : r_held_color;
            o_is_copy     <= r_copy_mode;
            o_last_span   <= (r_rows_left <= DW'(1));
        end
    end

    // ---------------- assertions ----------------
    a_active_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk_active |-> (r_rows_left != '0))
        else $error("walk active with no rows left");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && r_rows_left == DW'(1)) |=> !r_walk_active)
        else $error("walk still active after final span");

    a_mode_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_copy ? (o_span_color == '0) : (o_src_index == '0)))
        else $error("span carries fields of the wrong mode");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_span_length != '0))
        else $error("empty span emitted");

endmodule
